>>> src/cbmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbmt_pkg
// Shared types and constants for the counter bank with maximum tracking.
// ----------------------------------------------------------------------------
package cbmt_pkg;

    localparam int NUM_COUNTERS = 64;
    localparam int COUNT_BITS   = 16;
    localparam int CNT_AW       = $clog2(NUM_COUNTERS);
    localparam int TIE_W        = $clog2(NUM_COUNTERS + 1);
    localparam int SCAN_W       = CNT_AW + 1;

    typedef logic signed [COUNT_BITS-1:0] count_t;
    typedef logic [CNT_AW-1:0]            addr_t;
    typedef logic [TIE_W-1:0]             ties_t;
    typedef logic [1:0]                   func_t;

    localparam func_t FUNC_INC   = 2'd0;
    localparam func_t FUNC_DEC   = 2'd1;
    localparam func_t FUNC_CLR   = 2'd2;
    localparam func_t FUNC_QUERY = 2'd3;

    localparam count_t CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam count_t CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

endpackage

>>> src/cbmt_cnt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbmt_cnt_ram
// Counter memory: one write and one read port, registered read data.
// Per-entry valid bits make every counter read as zero after reset.
// ----------------------------------------------------------------------------
module cbmt_cnt_ram
    import cbmt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  addr_t  wr_addr,
    input  count_t wr_data,
    input  logic   rd_en,
    input  addr_t  rd_addr,
    output count_t rd_data
);

    count_t                  mem [NUM_COUNTERS];
    count_t                  rd_word_reg;
    logic [NUM_COUNTERS-1:0] vld_reg;
    logic                    rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // An entry never written since reset reads as zero.
    assign rd_data = rd_vld_reg ? rd_word_reg : '0;

endmodule

>>> src/counter_bank_max_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counter_bank_max_tracker
// Bank of saturating signed counters that tracks the maximum and its tie count.
// ----------------------------------------------------------------------------
// Usage:
// A request on the input channel (in_valid/in_ready) carries func and index.
// Each request produces exactly one response on the output channel
// (out_valid/out_ready): the counter's new value, the bank maximum and the
// number of counters holding that maximum.
// A request's accept cycle issues the counter memory read; the next cycle
// modifies and writes back, and loads the output register if it is free
// and no rescan is due. No new request is taken until the response is loaded.
// When the only counter holding the maximum drops, the bank is rescanned
// through the same read port before that request's response is loaded.
// Responses sit in an output register; a stalled receiver holds it. The
// block still takes a new request, and after write-back it holds that
// request's response until the previous one has been taken.
// Reset clears all counters to zero at once through per-entry valid bits, so
// no clearing pass is needed; the maximum is zero with all counters tied.
// ----------------------------------------------------------------------------
module counter_bank_max_tracker
    import cbmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [5:0]  index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] value,
    output logic [15:0] max_value,
    output logic [6:0]  num_at_max
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UPD  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [1:0]  state_reg, state_next;
    func_t       func_reg;
    addr_t       idx_reg;
    count_t      val_reg, val_next;
    count_t      max_reg, max_next;
    ties_t       ties_reg, ties_next;
    logic [SCAN_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic        scan_dv_reg, scan_dv_next;
    logic        scan_first_reg, scan_first_next;

    logic        out_valid_reg, out_valid_next;
    count_t      out_value_reg, out_max_reg;
    ties_t       out_ties_reg;
    logic        out_load;
    count_t      load_val, load_max;
    ties_t       load_ties;

    logic        rd_en, wr_en;
    addr_t       rd_addr;
    count_t      rd_data;
    count_t      upd_val;
    logic        out_free, accept, scan_issue;

    cbmt_cnt_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (upd_val),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign scan_issue = (state_reg == S_SCAN) && (scan_cnt_reg < SCAN_W'(NUM_COUNTERS));
    assign rd_en      = accept || scan_issue;
    assign rd_addr    = (state_reg == S_SCAN) ? scan_cnt_reg[CNT_AW-1:0] : index;
    assign wr_en      = (state_reg == S_UPD);

    always_comb
    begin
        case (func_reg)
            FUNC_INC:   upd_val = (rd_data != CNT_MAX) ? rd_data + count_t'(1) : rd_data;
            FUNC_DEC:   upd_val = (rd_data != CNT_MIN) ? rd_data - count_t'(1) : rd_data;
            FUNC_CLR:   upd_val = '0;
            FUNC_QUERY: upd_val = rd_data;
            default:    upd_val = rd_data;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        val_next        = val_reg;
        max_next        = max_reg;
        ties_next       = ties_reg;
        scan_cnt_next   = scan_cnt_reg;
        scan_dv_next    = 1'b0;
        scan_first_next = scan_first_reg;
        out_load        = 1'b0;
        load_val        = val_reg;
        load_max        = max_reg;
        load_ties       = ties_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                val_next = upd_val;
                if (upd_val > max_reg)
                begin
                    max_next  = upd_val;
                    ties_next = ties_t'(1);
                end
                else if (upd_val == max_reg)
                begin
                    if (rd_data != max_reg)
                    begin
                        ties_next = ties_reg + ties_t'(1);
                    end
                end
                else if (rd_data == max_reg)
                begin
                    ties_next = ties_reg - ties_t'(1);
                end

                // The last counter at the maximum fell: rebuild from the bank.
                if ((upd_val < max_reg) && (rd_data == max_reg) && (ties_reg == ties_t'(1)))
                begin
                    state_next      = S_SCAN;
                    scan_cnt_next   = '0;
                    scan_first_next = 1'b1;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    load_val   = upd_val;
                    load_max   = max_next;
                    load_ties  = ties_next;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_SCAN:
            begin
                if (scan_issue)
                begin
                    scan_cnt_next = scan_cnt_reg + SCAN_W'(1);
                    scan_dv_next  = 1'b1;
                end
                if (scan_dv_reg)
                begin
                    scan_first_next = 1'b0;
                    if (scan_first_reg || (rd_data > max_reg))
                    begin
                        max_next  = rd_data;
                        ties_next = ties_t'(1);
                    end
                    else if (rd_data == max_reg)
                    begin
                        ties_next = ties_reg + ties_t'(1);
                    end
                end
                if (!scan_issue && !scan_dv_reg)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            max_reg        <= '0;
            ties_reg       <= ties_t'(NUM_COUNTERS);
            scan_cnt_reg   <= '0;
            scan_dv_reg    <= 1'b0;
            scan_first_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            max_reg        <= max_next;
            ties_reg       <= ties_next;
            scan_cnt_reg   <= scan_cnt_next;
            scan_dv_reg    <= scan_dv_next;
            scan_first_reg <= scan_first_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            idx_reg  <= index;
        end
        val_reg <= val_next;
        if (out_load)
        begin
            out_value_reg <= load_val;
            out_max_reg   <= load_max;
            out_ties_reg  <= load_ties;
        end
    end

    assign out_valid  = out_valid_reg;
    assign value      = out_value_reg;
    assign max_value  = out_max_reg;
    assign num_at_max = out_ties_reg;

endmodule

>>> tb/counter_bank_max_tracker_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counter_bank_max_tracker_chk
// Watches both channels of the counter bank, keeps its own copy of the
// counters, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
module counter_bank_max_tracker_chk
    import cbmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  func,
    input  logic [5:0]  index,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] value,
    input  logic [15:0] max_value,
    input  logic [6:0]  num_at_max,
    output int          fail_count,
    output int          outstanding
);

    typedef struct packed {
        logic [15:0] value;
        logic [15:0] max_value;
        logic [6:0]  num_at_max;
    } bank_reply_t;

    count_t      bank [NUM_COUNTERS];
    bank_reply_t replies_due [$];

    // Applies one request to the shadow bank and returns the response it owes.
    // The maximum is recomputed from scratch every time, which is cheap here
    // and independent of how the block decides when to rescan.
    function automatic bank_reply_t apply_request(func_t op, addr_t idx);
        bank_reply_t r;
        count_t      best;
        ties_t       n;
        case (op)
            FUNC_INC: if (bank[idx] != CNT_MAX) bank[idx] = bank[idx] + 16'sd1;
            FUNC_DEC: if (bank[idx] != CNT_MIN) bank[idx] = bank[idx] - 16'sd1;
            FUNC_CLR: bank[idx] = '0;
            default: ;
        endcase
        best = bank[0];
        n    = '0;
        for (int k = 0; k < NUM_COUNTERS; k++)
        begin
            if (bank[k] > best)
            begin
                best = bank[k];
                n    = ties_t'(1);
            end
            else if (bank[k] == best)
            begin
                n = n + ties_t'(1);
            end
        end
        r.value      = bank[idx];
        r.max_value  = best;
        r.num_at_max = n;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bank_reply_t got;
        bank_reply_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_COUNTERS; k++)
                bank[k] = '0;
            replies_due.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // A response leaving at this edge always belongs to an older request,
            // so it is matched before the request taken at the same edge is queued.
            if (out_valid && out_ready)
            begin
                got.value      = value;
                got.max_value  = max_value;
                got.num_at_max = num_at_max;
                if (replies_due.size() == 0)
                begin
                    $error("response with no request pending: value %0d max_value %0d",
                           $signed(got.value), $signed(got.max_value));
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (got != want)
                        fail_count <= fail_count + 1;
                    if (got.value != want.value)
                        $error("value: expected %0d, actual %0d",
                               $signed(want.value), $signed(got.value));
                    if (got.max_value != want.max_value)
                        $error("max_value: expected %0d, actual %0d",
                               $signed(want.max_value), $signed(got.max_value));
                    if (got.num_at_max != want.num_at_max)
                        $error("num_at_max: expected %0d, actual %0d",
                               want.num_at_max, got.num_at_max);
                end
            end
            if (in_valid && in_ready)
                replies_due.insert(replies_due.size(),
                                   apply_request(func_t'(func), addr_t'(index)));
            outstanding <= replies_due.size();
        end
    end

endmodule

>>> tb/counter_bank_max_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counter_bank_max_tracker_tb
// Drives requests into the counter bank: a directed opening, then random
// traffic under three idling mixes. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module counter_bank_max_tracker_tb;
    import cbmt_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int ITEMS_PER_MIX = 345;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [5:0]  index;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] value;
    logic [15:0] max_value;
    logic [6:0]  num_at_max;

    int fail_count;
    int outstanding;
    int stall_cycles;
    int in_idle_pct;
    int out_idle_pct;
    bit quiet;

    counter_bank_max_tracker u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .index      (index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value      (value),
        .max_value  (max_value),
        .num_at_max (num_at_max)
    );

    counter_bank_max_tracker_chk u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .index       (index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value       (value),
        .max_value   (max_value),
        .num_at_max  (num_at_max),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver side: takes responses at random according to the current mix.
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= quiet || ($urandom_range(99) >= out_idle_pct);
        end
    end

    // Ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("counter_bank_max_tracker_tb failed");
            $finish;
        end
    end

    // Entered and left at a rising edge; the request is accepted at the edge
    // on which the task returns.
    task automatic send_req(input func_t op, input addr_t idx);
        while (!quiet && $urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        index    <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Holds the sender off until every response owed has come back.
    task automatic drain_replies();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic send_random_req(input addr_t hot_set [4]);
        addr_t idx;
        func_t op;
        int    pick;
        if ($urandom_range(99) < 70)
            idx = hot_set[$urandom_range(3)];
        else
            idx = addr_t'($urandom_range(NUM_COUNTERS - 1));
        pick = $urandom_range(99);
        if (pick < 40)
            op = FUNC_INC;
        else if (pick < 70)
            op = FUNC_DEC;
        else if (pick < 80)
            op = FUNC_CLR;
        else
            op = FUNC_QUERY;
        send_req(op, idx);
    endtask

    initial
    begin
        addr_t hot_set [4];
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        func         <= FUNC_INC;
        index        <= '0;
        in_idle_pct  <= 10;
        out_idle_pct <= 62;
        quiet        <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: ties after reset, a sole maximum falling, clears.
        send_req(FUNC_QUERY, 6'd0);
        send_req(FUNC_INC,   6'd0);
        send_req(FUNC_INC,   6'd63);
        send_req(FUNC_QUERY, 6'd63);
        send_req(FUNC_DEC,   6'd0);
        send_req(FUNC_DEC,   6'd63);
        send_req(FUNC_DEC,   6'd42);
        send_req(FUNC_CLR,   6'd42);
        send_req(FUNC_INC,   6'd21);
        send_req(FUNC_INC,   6'd21);
        send_req(FUNC_INC,   6'd5);
        send_req(FUNC_CLR,   6'd21);
        send_req(FUNC_DEC,   6'd5);
        send_req(FUNC_DEC,   6'd5);
        send_req(FUNC_QUERY, 6'd5);
        send_req(FUNC_CLR,   6'd5);
        send_req(FUNC_CLR,   6'd63);
        send_req(FUNC_QUERY, 6'd42);
        drain_replies();

        for (int mix = 0; mix < 3; mix++)
        begin
            case (mix)
                0: begin in_idle_pct <= 10; out_idle_pct <= 62; end
                1: begin in_idle_pct <= 62; out_idle_pct <= 10; end
                default: begin in_idle_pct <= 0; out_idle_pct <= 0; end
            endcase
            for (int h = 0; h < 4; h++)
                hot_set[h] = addr_t'($urandom_range(NUM_COUNTERS - 1));
            for (int n = 0; n < ITEMS_PER_MIX; n++)
            begin
                if (n % 40 == 0)
                    quiet <= ($urandom_range(3) == 0);
                send_random_req(hot_set);
            end
            quiet <= 1'b0;
            drain_replies();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("counter_bank_max_tracker_tb passed");
        else
            $display("counter_bank_max_tracker_tb failed");
        $finish;
    end

endmodule
